// ===== hdl/cd_pregap_index_mapper_macros.svh =====
// Assertion macros shared by the pregap mapper RTL.
`ifndef CD_PREGAP_INDEX_MAPPER_MACROS_SVH
`define CD_PREGAP_INDEX_MAPPER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication.
`define CDPG_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |-> (cons)) \
    else $error("cdpg assertion failed");

// Next-cycle implication.
`define CDPG_ASSERT_NXT(lbl, clk_i, rst_i, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (rst_i) (ante) |=> (cons)) \
    else $error("cdpg assertion failed");

`else

`define CDPG_ASSERT_IMP(lbl, clk_i, rst_i, ante, cons)
`define CDPG_ASSERT_NXT(lbl, clk_i, rst_i, ante, cons)

`endif

`endif

// ===== hdl/cdpg_pkg.sv =====
// Types and constants for the pregap index mapper.
`timescale 1ns / 1ps
`default_nettype none

package cdpg_pkg;

  // Approach windows before the index-1 boundary, in frames.
  localparam int SCAN_WINDOW  = 400;
  localparam int CLEAN_WINDOW = 150;

  // Compare width: holds any LBA, base+count and LBA-window without wrap.
  localparam int CW = 24;

  localparam logic [18:0] REL_MAX     = 19'h7FFFF;
  localparam logic [6:0]  TRACK_RESET = 7'd1;
  localparam logic [3:0]  QMODE_POS   = 4'd1;
  localparam logic [7:0]  IDX_PREGAP  = 8'd0;
  localparam logic [7:0]  IDX_START   = 8'd1;

  // Register indexes (byte address 4*i).
  localparam logic [1:0] REG_TRACK      = 2'd0;
  localparam logic [1:0] REG_INDEX1     = 2'd1;
  localparam logic [1:0] REG_SCAN_BASE  = 2'd2;
  localparam logic [1:0] REG_SCAN_COUNT = 2'd3;

  typedef enum logic [1:0] {
    PG_NONE    = 2'd0,
    PG_PRESENT = 2'd1,
    PG_UNKNOWN = 2'd2,
    PG_NODATA  = 2'd3
  } pg_state_t;

  typedef enum logic {
    OP_FRAME  = 1'b0,
    OP_FINISH = 1'b1
  } op_t;

  typedef struct packed {
    logic [6:0]         track_number;
    logic signed [20:0] bound_lba;
    logic signed [20:0] scan_base_lba;
    logic [19:0]        scan_count;
  } cfg_t;

  typedef struct packed {
    logic signed [20:0] frame_lba;
    logic               crc_good;
    logic [3:0]         q_mode;
    logic [7:0]         q_track;
    logic [7:0]         q_index;
    logic [6:0]         rel_minutes;
    logic [5:0]         rel_seconds;
    logic [6:0]         rel_frame;
  } frame_t;

  typedef struct packed {
    logic [6:0]         track_out;
    logic signed [20:0] boundary_lba;
    logic signed [20:0] q_idx1_lba;
    logic signed [20:0] pregap_start_lba;
    pg_state_t          gap_state;
    logic [18:0]        pregap_length;
    logic [7:0]         highest_index;
    logic [7:0]         clean_good_count;
    logic [7:0]         clean_bad_count;
  } map_t;

endpackage

`default_nettype wire

// ===== hdl/cdpg_evidence.sv =====
// Per-track evidence registers, frame classification and map entry build.
`timescale 1ns / 1ps
`default_nettype none
`include "cd_pregap_index_mapper_macros.svh"

module cdpg_evidence (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cdpg_pkg::cfg_t   cfg,
  input  wire logic             fire,
  input  wire cdpg_pkg::op_t    op,
  input  wire cdpg_pkg::frame_t frame,
  output cdpg_pkg::map_t        map
);

  localparam int CW = cdpg_pkg::CW;

  // Evidence registers
  logic                  idx0_seen, idx0_seen_next;
  logic [18:0]           longest_rel_time, longest_rel_time_next;
  logic [7:0]            max_index_seen, max_index_seen_next;
  logic signed [20:0]    first_idx1_lba, first_idx1_lba_next;
  logic                  idx1_valid, idx1_valid_next;
  logic [7:0]            good_count, good_count_next;
  logic [7:0]            bad_count, bad_count_next;
  cdpg_pkg::pg_state_t   verdict, verdict_next;

  logic signed [CW-1:0]  lba_w, l_w, base_w, end_w, lo_scan, lo_clean, lm1;
  logic                  in_window, pre_bnd, clean, pos, own, no_data, present;
  logic [19:0]           rel_raw;
  logic [18:0]           rel_sat;

  assign lba_w    = CW'(frame.frame_lba);
  assign l_w      = CW'(cfg.bound_lba);
  assign base_w   = CW'(cfg.scan_base_lba);
  assign end_w    = base_w + $signed({{(CW-20){1'b0}}, cfg.scan_count});
  assign lo_scan  = l_w - CW'(cdpg_pkg::SCAN_WINDOW);
  assign lo_clean = l_w - CW'(cdpg_pkg::CLEAN_WINDOW);
  assign lm1      = l_w - CW'(1);

  assign in_window = (lba_w >= lo_scan) && (lba_w <= l_w) &&
                     (lba_w >= base_w) && (lba_w < end_w);
  assign pre_bnd   = lba_w < l_w;
  assign clean     = pre_bnd && (lba_w >= lo_clean);
  assign pos       = frame.q_mode == cdpg_pkg::QMODE_POS;
  assign own       = frame.q_track == {1'b0, cfg.track_number};

  // (min*60 + sec)*75 + frame, as min*4500 + sec*75 + frame
  assign rel_raw = 20'(20'(frame.rel_minutes) * 20'd4500) +
                   20'(20'(frame.rel_seconds) * 20'd75) +
                   20'(frame.rel_frame);
  assign rel_sat = (rel_raw > {1'b0, cdpg_pkg::REL_MAX}) ? cdpg_pkg::REL_MAX : rel_raw[18:0];

  always_comb begin
    idx0_seen_next        = idx0_seen;
    longest_rel_time_next = longest_rel_time;
    max_index_seen_next   = max_index_seen;
    first_idx1_lba_next   = first_idx1_lba;
    idx1_valid_next       = idx1_valid;
    good_count_next       = good_count;
    bad_count_next        = bad_count;
    verdict_next          = verdict;
    if (fire) begin
      if (op == cdpg_pkg::OP_FINISH) begin
        idx0_seen_next        = 1'b0;
        longest_rel_time_next = '0;
        max_index_seen_next   = '0;
        first_idx1_lba_next   = '1;
        idx1_valid_next       = 1'b0;
        good_count_next       = '0;
        bad_count_next        = '0;
        verdict_next          = cdpg_pkg::PG_UNKNOWN;
      end else if (in_window) begin
        if (!frame.crc_good) begin
          if (clean && bad_count != 8'hFF) begin
            bad_count_next = bad_count + 8'd1;
          end
          if (pre_bnd) begin
            verdict_next = cdpg_pkg::PG_UNKNOWN;
          end
        end else begin
          if (clean && good_count != 8'hFF) begin
            good_count_next = good_count + 8'd1;
          end
          if (pos) begin
            if (pre_bnd) begin
              verdict_next = cdpg_pkg::PG_NONE;
            end
            if (own) begin
              if (frame.q_index > max_index_seen) begin
                max_index_seen_next = frame.q_index;
              end
              if (frame.q_index == cdpg_pkg::IDX_PREGAP && pre_bnd) begin
                idx0_seen_next = 1'b1;
                if (rel_sat > longest_rel_time) begin
                  longest_rel_time_next = rel_sat;
                end
              end else if (frame.q_index == cdpg_pkg::IDX_START) begin
                if (!idx1_valid || frame.frame_lba < first_idx1_lba) begin
                  first_idx1_lba_next = frame.frame_lba;
                  idx1_valid_next     = 1'b1;
                end
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx0_seen        <= 1'b0;
      longest_rel_time <= '0;
      max_index_seen   <= '0;
      first_idx1_lba   <= '1;
      idx1_valid       <= 1'b0;
      good_count       <= '0;
      bad_count        <= '0;
      verdict          <= cdpg_pkg::PG_UNKNOWN;
    end else begin
      idx0_seen        <= idx0_seen_next;
      longest_rel_time <= longest_rel_time_next;
      max_index_seen   <= max_index_seen_next;
      first_idx1_lba   <= first_idx1_lba_next;
      idx1_valid       <= idx1_valid_next;
      good_count       <= good_count_next;
      bad_count        <= bad_count_next;
      verdict          <= verdict_next;
    end
  end

  // Map entry from current evidence
  assign no_data = !((lm1 >= base_w) && (lm1 < end_w));
  assign present = idx0_seen && (longest_rel_time != '0);

  always_comb begin
    map.track_out        = cfg.track_number;
    map.boundary_lba     = cfg.bound_lba;
    map.q_idx1_lba       = '1;
    map.pregap_start_lba = '1;
    map.gap_state        = cdpg_pkg::PG_NODATA;
    map.pregap_length    = '0;
    map.highest_index    = '0;
    map.clean_good_count = '0;
    map.clean_bad_count  = '0;
    if (!no_data) begin
      if (idx1_valid) begin
        map.q_idx1_lba = first_idx1_lba;
      end
      map.highest_index    = max_index_seen;
      map.clean_good_count = good_count;
      map.clean_bad_count  = bad_count;
      if (present) begin
        map.gap_state        = cdpg_pkg::PG_PRESENT;
        map.pregap_length    = longest_rel_time;
        map.pregap_start_lba = cfg.bound_lba - {2'b00, longest_rel_time};
      end else begin
        map.gap_state = verdict;
      end
    end
  end

  `CDPG_ASSERT_NXT(a_clear_on_finish, clk, rst, fire && op == cdpg_pkg::OP_FINISH, good_count == 8'd0 && bad_count == 8'd0 && !idx1_valid && !idx0_seen)
  `CDPG_ASSERT_IMP(a_seen_longest, clk, rst, !idx0_seen, longest_rel_time == 19'd0)
  `CDPG_ASSERT_NXT(a_ignore_outside, clk, rst, fire && op == cdpg_pkg::OP_FRAME && !in_window, good_count == $past(good_count) && bad_count == $past(bad_count) && verdict == $past(verdict))

endmodule

`default_nettype wire

// ===== hdl/cd_pregap_index_mapper.sv =====
// Top level of the CD pregap index mapper: config port, input stage, output register.
// A finish transaction is registered in the input stage, then its map entry in the output register, shown on m_*.
// Throughput: one transaction per cycle; frame transactions produce no output.
// Input stalls only while a finish waits in the stage and the output register is held.
// Reset (rst, synchronous, high): pipeline empty, evidence cleared, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none
`include "cd_pregap_index_mapper_macros.svh"

module cd_pregap_index_mapper (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // Frame / finish stream in
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // frame_lba[20:0], crc_good[21], q_mode[25:22], q_track[33:26], q_index[41:34],
  // rel_minutes[48:42], rel_seconds[54:49], rel_frame[61:55], zero[63:62]
  input  wire logic [63:0]  s_tdata,
  // op[0]: 0 frame, 1 finish
  input  wire logic         s_tuser,
  // Map entry stream out
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // track_out[6:0], boundary_lba[27:7], q_idx1_lba[48:28], pregap_start_lba[69:49],
  // gap_state[71:70], pregap_length[90:72], highest_index[98:91],
  // clean_good_count[106:99], clean_bad_count[114:107], zero[119:115]
  output logic [119:0]      m_tdata
);

  cdpg_pkg::cfg_t   cfg;
  logic             cfg_wr;

  logic             s1_valid;
  cdpg_pkg::op_t    s1_op;
  cdpg_pkg::frame_t s1_frame;
  logic             s1_adv, stage_fire, map_load;

  cdpg_pkg::map_t   core_map, out_map;
  logic             out_valid;

  // ---------------------------------------------------------------
  // Configuration registers; word index from paddr[3:2]
  // ---------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_number  <= cdpg_pkg::TRACK_RESET;
      cfg.bound_lba     <= '0;
      cfg.scan_base_lba <= '0;
      cfg.scan_count    <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        cdpg_pkg::REG_TRACK:      cfg.track_number  <= pwdata[6:0];
        cdpg_pkg::REG_INDEX1:     cfg.bound_lba     <= pwdata[20:0];
        cdpg_pkg::REG_SCAN_BASE:  cfg.scan_base_lba <= pwdata[20:0];
        cdpg_pkg::REG_SCAN_COUNT: cfg.scan_count    <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      cdpg_pkg::REG_TRACK:      prdata = {25'd0, cfg.track_number};
      cdpg_pkg::REG_INDEX1:     prdata = 32'(cfg.bound_lba);
      cdpg_pkg::REG_SCAN_BASE:  prdata = 32'(cfg.scan_base_lba);
      cdpg_pkg::REG_SCAN_COUNT: prdata = {12'd0, cfg.scan_count};
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------
  // Input stage. Frames always drain; a finish drains only when the
  // output register is free or being emptied this cycle.
  // ---------------------------------------------------------------
  assign s1_adv     = !(s1_op == cdpg_pkg::OP_FINISH && out_valid && !m_tready);
  assign stage_fire = s1_valid && s1_adv;
  assign s_tready   = !s1_valid || s1_adv;
  assign map_load   = stage_fire && s1_op == cdpg_pkg::OP_FINISH;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s1_op    <= cdpg_pkg::OP_FRAME;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
      if (s_tvalid) begin
        s1_op <= cdpg_pkg::op_t'(s_tuser);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_frame.frame_lba   <= s_tdata[20:0];
      s1_frame.crc_good    <= s_tdata[21];
      s1_frame.q_mode      <= s_tdata[25:22];
      s1_frame.q_track     <= s_tdata[33:26];
      s1_frame.q_index     <= s_tdata[41:34];
      s1_frame.rel_minutes <= s_tdata[48:42];
      s1_frame.rel_seconds <= s_tdata[54:49];
      s1_frame.rel_frame   <= s_tdata[61:55];
    end
  end

  // Evidence and map build
  cdpg_evidence u_evidence (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .fire  (stage_fire),
    .op    (s1_op),
    .frame (s1_frame),
    .map   (core_map)
  );

  // ---------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (map_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (map_load) begin
      out_map <= core_map;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0,
                     out_map.clean_bad_count,
                     out_map.clean_good_count,
                     out_map.highest_index,
                     out_map.pregap_length,
                     out_map.gap_state,
                     out_map.pregap_start_lba,
                     out_map.q_idx1_lba,
                     out_map.boundary_lba,
                     out_map.track_out};

  `CDPG_ASSERT_IMP(a_ready_stall, clk, rst, !s_tready, s1_valid && s1_op == cdpg_pkg::OP_FINISH && out_valid && !m_tready)
  `CDPG_ASSERT_NXT(a_map_loaded, clk, rst, map_load, m_tvalid)
  `CDPG_ASSERT_NXT(a_frame_silent, clk, rst, stage_fire && s1_op == cdpg_pkg::OP_FRAME && !out_valid, !m_tvalid)

endmodule

`default_nettype wire
